// ----- rtl/core/lkv_pkg.sv -----
// Shared constants for the LRU key/value cache.
package lkv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

endpackage

// ----- rtl/core/lkv_tags.sv -----
// Valid bits, key row, recency ranks and replacement choice of the cache.
module lkv_tags #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                is_put,
  input  logic signed [lkv_pkg::KEY_W-1:0]    key,
  input  logic        [lkv_pkg::CAP_W-1:0]    cap,
  output logic                                hit,
  output logic                                wr_en,
  output logic        [IW-1:0]                idx
);
  import lkv_pkg::*;

  localparam int RW = IW;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0]            valid_r;
  logic signed [KEY_W-1:0]       key_r  [ENTRIES];
  logic [RW-1:0]                 rank_r [ENTRIES];
  logic [CW-1:0]                 count_r;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] free;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      free_idx;
  logic [RW-1:0]      hit_rank;
  logic [RW-1:0]      last_rank;
  logic [CW-1:0]      cap_eff;
  logic               any_free;
  logic               full;
  logic               evict;
  logic               ins;

  always_comb begin
    if (cap == '0) begin
      cap_eff = CW'(1);
    end else if (int'(cap) > ENTRIES) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(cap);
    end
  end

  assign full      = (count_r >= cap_eff);
  assign last_rank = RW'(count_r - CW'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == key);
      victim[i] = valid_r[i] && (rank_r[i] == last_rank);
    end
  end

  assign hit   = |match;
  assign evict = is_put && !hit && full;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      free[i] = !valid_r[i] || (evict && victim[i]);
    end
  end

  assign any_free = |free;
  assign ins      = is_put && !hit && any_free;

  // lowest-numbered match and lowest-numbered free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IW'(i);
      end
      if (free[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // one-hot select of the hit entry's rank
  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank = hit_rank | (match[i] ? rank_r[i] : '0);
    end
  end

  assign wr_en = en && is_put && (hit || ins);
  assign idx   = hit ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (en) begin
      if (hit) begin
        // move the hit entry to the front
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_r[i] <= rank_r[i] + RW'(1);
          end
        end
      end else if (ins) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IW'(i) == free_idx) begin
            valid_r[i] <= 1'b1;
            key_r[i]   <= key;
            rank_r[i]  <= '0;
          end else if (evict && victim[i]) begin
            valid_r[i] <= 1'b0;
          end else if (valid_r[i]) begin
            rank_r[i] <= rank_r[i] + RW'(1);
          end
        end
        if (!evict) begin
          count_r <= count_r + CW'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/core/lkv_data.sv -----
// Value memory of the cache: one write or one registered read per cycle.
module lkv_data #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic                              rd_en,
  input  logic        [IW-1:0]              addr,
  input  logic signed [lkv_pkg::VAL_W-1:0]  wr_data,
  output logic signed [lkv_pkg::VAL_W-1:0]  rd_data
);
  import lkv_pkg::*;

  logic signed [VAL_W-1:0] mem [ENTRIES];
  logic signed [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// Top level of the fully associative key/value cache with LRU replacement.
// Input channel: in_valid/in_stall carry one command beat (get or put) with
// its key and value. Result channel: out_valid/out_stall carry out_hit and
// out_read_value, one result beat per command beat, in order.
// A get that hits returns the stored value and refreshes the entry; a get
// miss and every put return all ones. A put on an absent key fills the
// lowest free entry, evicting the least recent one when the capacity in
// cfg_wr_data is reached.
// An accepted beat waits in the input register until the result register can take it.
// Throughput: one beat per cycle while the receiver does not stall; every key
// compare, rank update and the value memory access happen between the input
// register and the result register.
// The input register keeps taking beats while a result waits; when the
// receiver stalls, the result and one more input beat are held and in_stall
// rises.
// Reset clears all valid bits and the fill count and sets the capacity to 16;
// the cache is usable directly after reset.
module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic signed [lkv_pkg::KEY_W-1:0]  in_item_key,
  input  logic signed [lkv_pkg::VAL_W-1:0]  in_item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic signed [lkv_pkg::VAL_W-1:0]  out_read_value,
  input  logic                              cfg_wr_en,
  input  logic        [lkv_pkg::CAP_W-1:0]  cfg_wr_data
);
  import lkv_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic                    in_valid_r;
  logic                    cmd_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [VAL_W-1:0] value_r;
  logic                    out_valid_r;
  logic                    hit_r;
  logic                    put_r;
  logic [CAP_W-1:0]        cap_r;

  logic                    advance;
  logic                    go;
  logic                    accept;
  logic                    is_put;
  logic                    hit;
  logic                    wr_en;
  logic [IW-1:0]           idx;
  logic signed [VAL_W-1:0] rd_data;

  assign advance  = !out_valid_r || !out_stall;
  assign go       = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign is_put   = (cmd_r == CMD_PUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (go) begin
        in_valid_r <= 1'b0;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      key_r   <= in_item_key;
      value_r <= in_item_value;
    end
    if (go) begin
      hit_r <= hit;
      put_r <= is_put;
    end
  end

  lkv_tags #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_tags (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (go),
    .is_put (is_put),
    .key    (key_r),
    .cap    (cap_r),
    .hit    (hit),
    .wr_en  (wr_en),
    .idx    (idx)
  );

  lkv_data #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_data (
    .clk     (clk),
    .wr_en   (wr_en),
    .rd_en   (go && !is_put),
    .addr    (idx),
    .wr_data (value_r),
    .rd_data (rd_data)
  );

  assign out_valid      = out_valid_r;
  assign out_hit        = hit_r;
  assign out_read_value = (hit_r && !put_r) ? rd_data : MISS_VALUE;

endmodule
